// ===== design/dsad_pkg.sv =====
// shared types and constants for the dual sensor activity detector
// no dependencies; imported by every module of the block
`default_nettype none

package dsad_pkg;

    localparam int unsigned MS_PER_SEC = 1000;
    // widest delay in ms: 65535 s * 1000 fits in 26 bits
    localparam int unsigned DELAY_W    = 26;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned VAL_W      = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DET_EN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_EN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUR_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOT_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CUR_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CUR_STOP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MOT_START = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MOT_STOP  = 3'd7;

    // bit positions in the enable registers
    localparam int unsigned EN_CUR       = 0;
    localparam int unsigned EN_MOT       = 1;
    localparam int unsigned NOTIFY_START = 0;
    localparam int unsigned NOTIFY_DONE  = 1;

    // reset values
    localparam logic [1:0]         RST_DET_EN    = 2'd3;
    localparam logic [1:0]         RST_NOTIFY_EN = 2'd3;
    localparam logic [VAL_W-1:0]   RST_CUR_THR   = 16'd500;
    localparam logic [VAL_W-1:0]   RST_MOT_THR   = 16'd10;
    localparam logic [DELAY_W-1:0] RST_START_MS  = DELAY_W'(10 * MS_PER_SEC);
    localparam logic [DELAY_W-1:0] RST_STOP_MS   = DELAY_W'(60 * MS_PER_SEC);

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_DONE  = 2'd2
    } t_event;

    typedef struct packed {
        logic [DELAY_W-1:0] start_ms;
        logic [DELAY_W-1:0] stop_ms;
    } t_chan_time;

    typedef struct packed {
        logic [1:0]       det_en;
        logic [1:0]       notify_en;
        logic [VAL_W-1:0] cur_thr;
        logic [VAL_W-1:0] mot_thr;
        t_chan_time       cur_time;
        t_chan_time       mot_time;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [VAL_W-1:0]  current_ma;
        logic [VAL_W-1:0]  dev_x;
        logic [VAL_W-1:0]  dev_y;
        logic [VAL_W-1:0]  dev_z;
    } t_in_req;

    typedef struct packed {
        logic       cycle_active;
        logic       current_present;
        logic       motion_present;
        logic       current_raw_above;
        logic       motion_raw_above;
        logic [1:0] event_code;
        logic       no_detectors;
    } t_out_req;

endpackage

`default_nettype wire

// ===== design/dsad_cfg.sv =====
// configuration register file; delays are kept in milliseconds
// depends on dsad_pkg
`default_nettype none

module dsad_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [dsad_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [dsad_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output dsad_pkg::t_cfg                          o_cfg
);
    import dsad_pkg::*;

    t_cfg               r_cfg;
    logic [DELAY_W-1:0] n_delay_ms;

    // seconds to ms, done once at write time
    assign n_delay_ms = DELAY_W'(i_cfg_data) * DELAY_W'(MS_PER_SEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.det_en            <= RST_DET_EN;
            r_cfg.notify_en         <= RST_NOTIFY_EN;
            r_cfg.cur_thr           <= RST_CUR_THR;
            r_cfg.mot_thr           <= RST_MOT_THR;
            r_cfg.cur_time.start_ms <= RST_START_MS;
            r_cfg.cur_time.stop_ms  <= RST_STOP_MS;
            r_cfg.mot_time.start_ms <= RST_START_MS;
            r_cfg.mot_time.stop_ms  <= RST_STOP_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DET_EN:    r_cfg.det_en            <= i_cfg_data[1:0];
                CFG_NOTIFY_EN: r_cfg.notify_en         <= i_cfg_data[1:0];
                CFG_CUR_THR:   r_cfg.cur_thr           <= i_cfg_data;
                CFG_MOT_THR:   r_cfg.mot_thr           <= i_cfg_data;
                CFG_CUR_START: r_cfg.cur_time.start_ms <= n_delay_ms;
                CFG_CUR_STOP:  r_cfg.cur_time.stop_ms  <= n_delay_ms;
                CFG_MOT_START: r_cfg.mot_time.start_ms <= n_delay_ms;
                CFG_MOT_STOP:  r_cfg.mot_time.stop_ms  <= n_delay_ms;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/dsad_chan.sv =====
// start/stop debounce qualifier for one sensor channel, holds its own state
// depends on dsad_pkg
`default_nettype none

module dsad_chan (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_step,
    input  wire logic                           i_in_cycle,
    input  wire logic                           i_high,
    input  wire logic [dsad_pkg::TIME_W-1:0]    i_now,
    input  wire dsad_pkg::t_chan_time           i_time,
    output logic                                o_detected
);
    import dsad_pkg::*;

    logic              r_detected, n_detected;
    logic              r_pending, n_pending;
    logic [TIME_W-1:0] r_since, n_since;
    logic [TIME_W-1:0] since_eff;
    logic [TIME_W:0]   due;
    logic              hit;

    // timer opens at this sample if not already running
    assign since_eff = r_pending ? r_since : i_now;
    assign due = {1'b0, since_eff}
               + (TIME_W + 1)'(i_in_cycle ? i_time.stop_ms : i_time.start_ms);
    assign hit = {1'b0, i_now} >= due;

    always_comb begin
        n_detected = r_detected;
        n_pending  = r_pending;
        n_since    = r_since;
        if (i_step) begin
            if (i_in_cycle) begin
                if (r_detected && !i_high) begin
                    n_pending = 1'b1;
                    n_since   = since_eff;
                    if (hit) begin
                        n_detected = 1'b0;
                        n_pending  = 1'b0;
                    end
                end else if (!r_detected && i_high) begin
                    n_detected = 1'b1;
                    n_pending  = 1'b0;
                end
                // high while detected: open stop timer is left as is
            end else begin
                if (i_high) begin
                    n_pending = 1'b1;
                    n_since   = since_eff;
                    if (hit) begin
                        n_detected = 1'b1;
                        n_pending  = 1'b0;
                    end
                end else begin
                    n_pending = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detected <= 1'b0;
            r_pending  <= 1'b0;
        end else begin
            r_detected <= n_detected;
            r_pending  <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        r_since <= n_since;
    end

    assign o_detected = n_detected;

endmodule

`default_nettype wire

// ===== design/dual_sensor_activity_detector.sv =====
// dual sensor activity detector: current and motion channels, cycle start/end events
// a request taken into the input register is computed into the result register
// throughput: one request per cycle while the result side does not stall, set by
// the single compute stage between the input register and the result register
// reset: synchronous active low; clears cycle and channel flags and loads
// register defaults; depends on dsad_pkg, dsad_cfg, dsad_chan
`default_nettype none

module dual_sensor_activity_detector (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire dsad_pkg::t_in_req                  i_in_req,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output dsad_pkg::t_out_req                      o_out_req,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [dsad_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [dsad_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import dsad_pkg::*;

    t_cfg       cfg;

    // input register
    logic       r_in_valid;
    t_in_req    r_in;

    // result register
    logic       r_out_valid;
    t_out_req   r_out, n_out;

    // cycle state
    logic       r_in_cycle, n_in_cycle;
    t_event     n_event;

    logic       step;
    logic       cur_en, mot_en, none;
    logic       cur_high, mot_high;
    logic       cur_det, mot_det, any_det;
    logic [VAL_W-1:0] max_xy, max_dev;

    // a request moves into the result register when that register is free
    // or being emptied in this cycle
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_req;
        end
    end

    dsad_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign cur_en = cfg.det_en[EN_CUR];
    assign mot_en = cfg.det_en[EN_MOT];
    assign none   = !cur_en && !mot_en;

    // motion reading is the largest of the three axis deviations
    assign max_xy  = (r_in.dev_y > r_in.dev_x) ? r_in.dev_y : r_in.dev_x;
    assign max_dev = (r_in.dev_z > max_xy) ? r_in.dev_z : max_xy;

    // raw compares read as 0 on a disabled channel
    assign cur_high = cur_en && (r_in.current_ma >= cfg.cur_thr);
    assign mot_high = mot_en && (max_dev >= cfg.mot_thr);

    // disabled channels hold their state
    dsad_chan u_cur (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step && cur_en),
        .i_in_cycle (r_in_cycle),
        .i_high     (cur_high),
        .i_now      (r_in.now_ms),
        .i_time     (cfg.cur_time),
        .o_detected (cur_det)
    );

    dsad_chan u_mot (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step && mot_en),
        .i_in_cycle (r_in_cycle),
        .i_high     (mot_high),
        .i_now      (r_in.now_ms),
        .i_time     (cfg.mot_time),
        .o_detected (mot_det)
    );

    // only enabled channels count toward starting or ending a cycle
    assign any_det = (cur_en && cur_det) || (mot_en && mot_det);

    always_comb begin
        n_in_cycle = r_in_cycle;
        n_event    = EV_NONE;
        if (step && !none) begin
            if (!r_in_cycle && any_det) begin
                n_in_cycle = 1'b1;
                if (cfg.notify_en[NOTIFY_START]) begin
                    n_event = EV_START;
                end
            end else if (r_in_cycle && !any_det) begin
                n_in_cycle = 1'b0;
                if (cfg.notify_en[NOTIFY_DONE]) begin
                    n_event = EV_DONE;
                end
            end
        end
    end

    always_comb begin
        n_out.cycle_active      = n_in_cycle;
        n_out.current_present   = cur_det;
        n_out.motion_present    = mot_det;
        n_out.current_raw_above = cur_high;
        n_out.motion_raw_above  = mot_high;
        n_out.event_code        = n_event;
        n_out.no_detectors      = none;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cycle  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_cycle <= n_in_cycle;
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // input side is held back only by a full, stalled result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // a computed request always shows up as a result
    a_step_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("result lost after compute");

    // a start event leaves a cycle running, a done event leaves none
    a_event_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> ((r_out.event_code != EV_START) || r_out.cycle_active)
                 && ((r_out.event_code != EV_DONE) || !r_out.cycle_active))
        else $error("event code disagrees with cycle state");

    // with both channels off nothing is reported and the cycle holds
    a_none_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && none) |=> (r_out.event_code == EV_NONE) && !r_out.current_raw_above
                           && !r_out.motion_raw_above && $stable(r_in_cycle))
        else $error("activity reported with both channels disabled");

endmodule

`default_nettype wire

// ===== tb/dual_sensor_activity_detector_test.sv =====
// self-checking testbench for the dual sensor activity detector
// predicts every status request from its own copy of the debounce and cycle logic
// depends on dsad_pkg and dual_sensor_activity_detector
`timescale 1ns / 1ps

module dual_sensor_activity_detector_test;
    import dsad_pkg::*;

    localparam int unsigned RUN_LIMIT = 200_000;

    typedef struct packed {
        logic        detected;
        logic        pending;
        logic [31:0] since;
    } t_chan_state;

    // block ports
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_req               in_req;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_req              o_out_req;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // register image, written to the block by load_settings
    logic [15:0] reg_val [8];

    // predicted detector state
    logic        cycle_on;
    t_chan_state cur_chan;
    t_chan_state mot_chan;

    // expected status requests, oldest first
    t_out_req    status_due [$];

    logic [31:0] clock_ms;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_req;
    int unsigned hold_left;
    int unsigned error_count;
    int unsigned result_count;
    int unsigned cycle_count;

    dual_sensor_activity_detector u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    // deadline reached once now >= since + secs * 1000, taken 33 bits wide
    function automatic logic delay_expired(logic [31:0] now, logic [31:0] since,
                                           logic [15:0] secs);
        logic [32:0] due;
        due = 33'(since) + 33'(secs) * 33'(MS_PER_SEC);
        return {1'b0, now} >= due;
    endfunction

    // start/stop debounce of one channel; reads the cycle flag from before this sample
    function automatic t_chan_state debounce(t_chan_state c, logic high, logic [31:0] now,
                                             logic [15:0] start_s, logic [15:0] stop_s);
        if (cycle_on) begin
            if (c.detected && !high) begin
                if (!c.pending) begin
                    c.pending = 1'b1;
                    c.since   = now;
                end
                if (delay_expired(now, c.since, stop_s)) begin
                    c.detected = 1'b0;
                    c.pending  = 1'b0;
                end
            end else if (!c.detected && high) begin
                // rises at once; a stop timer left open while high is kept otherwise
                c.detected = 1'b1;
                c.pending  = 1'b0;
            end
        end else if (high) begin
            if (!c.pending) begin
                c.pending = 1'b1;
                c.since   = now;
            end
            if (delay_expired(now, c.since, start_s)) begin
                c.detected = 1'b1;
                c.pending  = 1'b0;
            end
        end else begin
            c.pending = 1'b0;
        end
        return c;
    endfunction

    // status expected for one accepted sample, advancing the predicted state
    function automatic t_out_req next_status(t_in_req s);
        t_out_req    r;
        logic        cur_on;
        logic        mot_on;
        logic        any_det;
        logic [15:0] peak;
        r            = '0;
        r.event_code = EV_NONE;
        cur_on       = reg_val[CFG_DET_EN][EN_CUR];
        mot_on       = reg_val[CFG_DET_EN][EN_MOT];
        if (cur_on || mot_on) begin
            if (cur_on) begin
                r.current_raw_above = s.current_ma >= reg_val[CFG_CUR_THR];
                cur_chan = debounce(cur_chan, r.current_raw_above, s.now_ms,
                                    reg_val[CFG_CUR_START], reg_val[CFG_CUR_STOP]);
            end
            if (mot_on) begin
                peak = s.dev_x;
                if (s.dev_y > peak) peak = s.dev_y;
                if (s.dev_z > peak) peak = s.dev_z;
                r.motion_raw_above = peak >= reg_val[CFG_MOT_THR];
                mot_chan = debounce(mot_chan, r.motion_raw_above, s.now_ms,
                                    reg_val[CFG_MOT_START], reg_val[CFG_MOT_STOP]);
            end
            // disabled channels never start or hold a cycle
            any_det = (cur_on && cur_chan.detected) || (mot_on && mot_chan.detected);
            if (!cycle_on && any_det) begin
                cycle_on = 1'b1;
                if (reg_val[CFG_NOTIFY_EN][NOTIFY_START]) r.event_code = EV_START;
            end else if (cycle_on && !any_det) begin
                cycle_on = 1'b0;
                if (reg_val[CFG_NOTIFY_EN][NOTIFY_DONE]) r.event_code = EV_DONE;
            end
        end else begin
            // both channels off: everything holds
            r.no_detectors = 1'b1;
        end
        r.cycle_active    = cycle_on;
        r.current_present = cur_chan.detected;
        r.motion_present  = mot_chan.detected;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // one sample request; valid is left high so back-to-back requests need no toggle
    task automatic send_sample(t_in_req sample);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        in_req     <= sample;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        status_due.push_back(next_status(sample));
    endtask

    task automatic send_at(logic [31:0] now, logic [15:0] cur,
                           logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
        t_in_req s;
        s.now_ms     = now;
        s.current_ma = cur;
        s.dev_x      = dx;
        s.dev_y      = dy;
        s.dev_z      = dz;
        clock_ms     = now;
        send_sample(s);
    endtask

    // registers change only with the block drained
    task automatic load_settings();
        int idx;
        i_in_valid <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        for (idx = 0; idx < 8; idx++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(idx);
            i_cfg_data <= reg_val[idx];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // reading on the requested side of a threshold
    function automatic logic [15:0] pick_level(logic high, logic [15:0] thr);
        if (high) return 16'($urandom_range(32'hFFFF, thr));
        if (thr == 16'd0) return 16'($urandom);
        return 16'($urandom_range(thr - 16'd1, 0));
    endfunction

    function automatic t_in_req make_sample(logic cur_hi, logic mot_hi);
        t_in_req     s;
        logic [15:0] mthr;
        mthr         = reg_val[CFG_MOT_THR];
        s.now_ms     = clock_ms;
        s.current_ma = pick_level(cur_hi, reg_val[CFG_CUR_THR]);
        s.dev_x      = pick_level(1'b0, mthr);
        s.dev_y      = pick_level(1'b0, mthr);
        s.dev_z      = pick_level(1'b0, mthr);
        // motion high needs only one axis above
        if (mot_hi) begin
            case ($urandom_range(2))
                0: s.dev_x = pick_level(1'b1, mthr);
                1: s.dev_y = pick_level(1'b1, mthr);
                default: s.dev_z = pick_level(1'b1, mthr);
            endcase
        end
        return s;
    endfunction

    // mostly sub-second steps, now and then a long gap or a step back
    function automatic void advance_clock();
        logic [32:0] sum;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 2 && clock_ms >= 32'd5000) begin
            clock_ms = clock_ms - $urandom_range(5000);
        end else begin
            if (r < 5 && !clock_ms[31]) sum = clock_ms + $urandom_range(70_000_000);
            else sum = clock_ms + $urandom_range(1200);
            clock_ms = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
    endfunction

    function automatic logic [15:0] pick_reg(int unsigned typical);
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(typical));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic compare_field(string field, logic [1:0] want, logic [1:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= 10)
                $display("status %0d: %s expected %0d, got %0d",
                         result_count, field, want, got);
        end
    endtask

    task automatic check_status(t_out_req got);
        t_out_req want;
        result_count++;
        if (status_due.size() == 0) begin
            error_count++;
            if (error_count <= 10)
                $display("status %0d arrived with nothing expected", result_count);
            return;
        end
        want = status_due.pop_front();
        compare_field("cycle_active", want.cycle_active, got.cycle_active);
        compare_field("current_present", want.current_present, got.current_present);
        compare_field("motion_present", want.motion_present, got.motion_present);
        compare_field("current_raw_above", want.current_raw_above, got.current_raw_above);
        compare_field("motion_raw_above", want.motion_raw_above, got.motion_raw_above);
        compare_field("event_code", want.event_code, got.event_code);
        compare_field("no_detectors", want.no_detectors, got.no_detectors);
    endtask

    // status requests are sampled before this edge's updates land
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) check_status(o_out_req);
        end
    end

    // result side stall: random per mode, or a long hold when one is asked for
    initial begin
        i_out_stall <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset settings: 10 s start, 60 s stop, thresholds 500 mA and 0.10 g
    task automatic test_debounce_deadlines();
        send_at(32'd0,      16'd0,   16'd0, 16'd0, 16'd0);  // both low
        send_at(32'd1000,   16'd500, 16'd0, 16'd0, 16'd10); // exactly at threshold, timers open
        send_at(32'd10999,  16'd600, 16'd11, 16'd0, 16'd0); // one ms short of the start delay
        send_at(32'd11000,  16'd500, 16'd0, 16'd12, 16'd0); // start delay met, cycle starts
        send_at(32'd20000,  16'd499, 16'd9, 16'd9, 16'd9);  // both low, stop timers open
        send_at(32'd50000,  16'd900, 16'd30, 16'd0, 16'd0); // high again, timers kept open
        send_at(32'd80000,  16'd0,   16'd0, 16'd0, 16'd0);  // old stop deadline hit, cycle ends
        send_at(32'd80000,  16'd700, 16'd0, 16'd0, 16'd20); // same time, start timers again
        send_at(32'd80500,  16'd0,   16'd0, 16'd0, 16'd0);  // low outside a cycle drops them
    endtask

    task automatic test_channel_enables();
        reg_val[CFG_DET_EN]    = 16'(1 << EN_CUR);
        reg_val[CFG_NOTIFY_EN] = 16'(1 << NOTIFY_DONE);
        reg_val[CFG_CUR_START] = 16'd0;
        reg_val[CFG_CUR_STOP]  = 16'd0;
        reg_val[CFG_MOT_START] = 16'd0;
        reg_val[CFG_MOT_STOP]  = 16'd0;
        load_settings();
        send_at(32'd100_000, 16'd800, 16'd50, 16'd50, 16'd50); // start, not reported
        send_at(32'd100_100, 16'd0,   16'd50, 16'd50, 16'd50); // zero stop delay, end reported
        reg_val[CFG_DET_EN]    = 16'(1 << EN_MOT);
        reg_val[CFG_NOTIFY_EN] = 16'(1 << NOTIFY_START);
        load_settings();
        send_at(32'd100_200, 16'd800, 16'd0, 16'd0, 16'd40);   // motion only starts a cycle
        reg_val[CFG_DET_EN] = 16'd0;
        load_settings();
        send_at(32'd100_300, 16'd800, 16'd50, 16'd50, 16'd50); // nothing enabled, state held
        reg_val[CFG_DET_EN]    = 16'd3;
        reg_val[CFG_NOTIFY_EN] = 16'd3;
        load_settings();
        send_at(32'd100_400, 16'd0, 16'd0, 16'd0, 16'd0);      // motion drops, cycle ends
    endtask

    task automatic test_field_extremes();
        reg_val[CFG_CUR_THR]   = 16'hFFFF;
        reg_val[CFG_MOT_THR]   = 16'd0;
        reg_val[CFG_CUR_START] = 16'd0;
        reg_val[CFG_CUR_STOP]  = 16'hFFFF;
        reg_val[CFG_MOT_START] = 16'd0;
        reg_val[CFG_MOT_STOP]  = 16'hFFFF;
        load_settings();
        send_at(32'hFFFF_FFF0, 16'hFFFF, 16'd0, 16'd0, 16'd0);  // top of range, zero threshold
        send_at(32'hFFFF_FFF8, 16'hFFFE, 16'd0, 16'd0, 16'd0);  // stop deadline beyond 32 bits
        send_at(32'hFFFF_FFFF, 16'd0,    16'd0, 16'd0, 16'd0);
        send_at(32'h0000_1000, 16'd0,    16'd0, 16'd0, 16'd0);  // time steps backwards
        reg_val[CFG_CUR_THR] = 16'd0;
        reg_val[CFG_MOT_THR] = 16'hFFFF;
        load_settings();
        send_at(32'h8000_0000, 16'd0,    16'hFFFF, 16'h5555, 16'hAAAA);
        send_at(32'h8000_0001, 16'd0,    16'd0,    16'hFFFF, 16'd0);
        send_at(32'h8000_0002, 16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFE); // motion just below
    endtask

    // result side holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        hold_req = 300;
        repeat (40) begin
            advance_clock();
            send_sample(make_sample(1'($urandom_range(1)), 1'b1));
        end
    endtask

    // sessions of random settings, each a run of steady high or low stretches
    task automatic test_random_sessions(int unsigned target);
        int unsigned counted;
        int unsigned session_len;
        int unsigned run_len;
        int unsigned sent;
        logic        cur_hi;
        logic        mot_hi;
        counted = 0;
        while (counted < target) begin
            // upper bits of the narrow registers are don't-care
            if ($urandom_range(19) == 0)
                reg_val[CFG_DET_EN] = {14'($urandom), 2'd0};
            else
                reg_val[CFG_DET_EN] = {14'($urandom), 2'($urandom_range(3, 1))};
            reg_val[CFG_NOTIFY_EN] = {14'($urandom), 2'($urandom_range(3))};
            reg_val[CFG_CUR_THR]   = pick_reg(2000);
            reg_val[CFG_MOT_THR]   = pick_reg(300);
            reg_val[CFG_CUR_START] = pick_reg(5);
            reg_val[CFG_CUR_STOP]  = pick_reg(5);
            reg_val[CFG_MOT_START] = pick_reg(5);
            reg_val[CFG_MOT_STOP]  = pick_reg(5);
            load_settings();
            if ($urandom_range(7) == 0)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(150_000);
            else if (clock_ms > 32'hC000_0000)
                clock_ms = $urandom_range(2000);
            session_len = $urandom_range(90, 40);
            sent = 0;
            while (sent < session_len) begin
                cur_hi  = 1'($urandom_range(1));
                mot_hi  = 1'($urandom_range(1));
                run_len = $urandom_range(12, 1);
                repeat (run_len) begin
                    advance_clock();
                    // some noise inside the stretches
                    if ($urandom_range(9) == 0)
                        send_sample(make_sample(1'($urandom_range(1)),
                                                1'($urandom_range(1))));
                    else
                        send_sample(make_sample(cur_hi, mot_hi));
                    sent++;
                end
            end
            // samples with both channels off leave the detector state as it is and are not counted
            if (reg_val[CFG_DET_EN][1:0] != 2'd0) counted += sent;
        end
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        in_req     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        hold_req     = 0;
        error_count  = 0;
        result_count = 0;
        clock_ms     = 32'd0;
        cycle_on     = 1'b0;
        cur_chan     = '0;
        mot_chan     = '0;
        reg_val[CFG_DET_EN]    = 16'(RST_DET_EN);
        reg_val[CFG_NOTIFY_EN] = 16'(RST_NOTIFY_EN);
        reg_val[CFG_CUR_THR]   = RST_CUR_THR;
        reg_val[CFG_MOT_THR]   = RST_MOT_THR;
        reg_val[CFG_CUR_START] = 16'd10;
        reg_val[CFG_CUR_STOP]  = 16'd60;
        reg_val[CFG_MOT_START] = 16'd10;
        reg_val[CFG_MOT_STOP]  = 16'd60;
        // busy receiver first, slow sender second
        send_idle_pct = 17;
        recv_idle_pct = 78;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_debounce_deadlines();
        test_channel_enables();
        test_field_extremes();
        test_random_sessions(500);

        send_idle_pct = 78;
        recv_idle_pct = 17;
        test_random_sessions(500);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random_sessions(500);

        // drain and let the pipeline settle
        i_in_valid <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && status_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
